@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL; only pst_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/pst_pkg.sv @@
package pst_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam logic [15:0] ATTACH_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    K_ALLOC  = 3'd0,
    K_ATTACH = 3'd1,
    K_DETACH = 3'd2,
    K_FREE   = 3'd3,
    K_SCAN   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_PRESENT = 3'd2,
    STS_IGNORED = 3'd3,
    STS_NONE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ATTACH_INC,
    WR_FREE,
    WR_TAKE,
    WR_DETACH
  } wr_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FRD,
    S_FCHK,
    S_HRD,
    S_HCHK,
    S_DRD,
    S_DCHK,
    S_SRD,
    S_SCHK
  } state_t;

  typedef struct packed {
    logic    clr_wr;
    logic    latch;
    logic    load_idx;
    logic    cnt_inc;
    logic    rd_cnt;
    logic    rd_head;
    wr_op_t  wr_op;
    logic    take_one;
    logic    emit;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic in_idx_ok;
    logic match;
    logic cnt_last;
    logic head_ok;
    logic det_ok;
    logic used;
  } sts_t;

endpackage

@@ rtl/pst_ctrl.sv @@
`include "assert_macros.svh"

module pst_ctrl import pst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_kind,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic       in_check_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      kind_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.wr_op    = WR_NONE;
    cmd.status   = STS_OK;
    cmd.take_one = (kind_r == K_ATTACH);
    busy         = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          kind_nxt  = in_kind;
          case (in_kind)
            K_ALLOC, K_ATTACH, K_FREE: state_nxt = S_FRD;
            K_DETACH: begin
              cmd.load_idx = 1'b1;
              if (sts.in_idx_ok) state_nxt = S_DRD;
              else begin
                cmd.emit   = 1'b1;
                cmd.status = STS_IGNORED;
              end
            end
            K_SCAN: begin
              cmd.load_idx = 1'b1;
              if (sts.in_idx_ok) state_nxt = S_SRD;
              else begin
                cmd.emit   = 1'b1;
                cmd.status = STS_NONE;
              end
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.status = STS_IGNORED;
            end
          endcase
        end
      end
      S_FRD: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_FCHK;
      end
      S_FCHK: begin
        if (sts.match) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
          case (kind_r)
            K_ALLOC:  cmd.status = STS_PRESENT;
            K_ATTACH: cmd.wr_op  = WR_ATTACH_INC;
            default:  cmd.wr_op  = WR_FREE;
          endcase
        end else if (sts.cnt_last) begin
          if (kind_r == K_FREE) begin
            cmd.emit   = 1'b1;
            cmd.status = STS_IGNORED;
            state_nxt  = S_IDLE;
          end else if (sts.head_ok) begin
            state_nxt = S_HRD;
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = STS_FULL;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FRD;
        end
      end
      S_HRD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_HCHK;
      end
      S_HCHK: begin
        cmd.wr_op = WR_TAKE;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DRD: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_DCHK;
      end
      S_DCHK: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.det_ok) cmd.wr_op = WR_DETACH;
        else cmd.status = STS_IGNORED;
      end
      S_SRD: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_SCHK;
      end
      S_SCHK: begin
        if (sts.used) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.cnt_last) begin
          cmd.emit   = 1'b1;
          cmd.status = STS_NONE;
          state_nxt  = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_check_st = (state_r == S_FCHK) || (state_r == S_HCHK) || (state_r == S_DCHK);

  `ASSERT_CLK(a_wr_in_check, clk, rst_n, (cmd.wr_op != WR_NONE) |-> in_check_st)
  `ASSERT_CLK(a_emit_ends, clk, rst_n, cmd.emit |-> (state_nxt == S_IDLE))
  `ASSERT_NEVER(a_clear_quiet, clk, rst_n, cmd.clr_wr && (cmd.emit || cmd.wr_op != WR_NONE))
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (start && !busy && !cmd.emit) |=> busy)

endmodule

@@ rtl/pst_dp.sv @@
module pst_dp import pst_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [30:0] in_owner_id,
  input  logic [5:0]  in_slot_index,
  input  logic [31:0] in_generation,
  input  logic [62:0] in_now_time,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [31:0] out_generation_out,
  output logic [15:0] out_attach_out,
  output logic [30:0] out_owner_out,
  output logic [62:0] out_created_out
);

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] NULL_SLOT = CW'(MAX_SLOTS);
  localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_SLOTS - 1);

  logic        mem_used    [MAX_SLOTS];
  logic [30:0] mem_owner   [MAX_SLOTS];
  logic [15:0] mem_attach  [MAX_SLOTS];
  logic [31:0] mem_gen     [MAX_SLOTS];
  logic [62:0] mem_created [MAX_SLOTS];
  logic [CW-1:0] mem_next  [MAX_SLOTS];

  logic [CW-1:0] cnt_r, cnt_nxt, head_r, head_nxt;
  logic [AW-1:0] addr_r, rd_addr, wr_addr;
  logic [30:0]   who_r;
  logic [31:0]   gen_r;
  logic [62:0]   now_r;

  logic          rd_used_r;
  logic [30:0]   rd_owner_r;
  logic [15:0]   rd_attach_r;
  logic [31:0]   rd_gen_r;
  logic [62:0]   rd_created_r;
  logic [CW-1:0] rd_next_r;

  logic          nw_used;
  logic [30:0]   nw_owner;
  logic [15:0]   nw_attach;
  logic [31:0]   nw_gen;
  logic [62:0]   nw_created;
  logic [CW-1:0] nw_next;
  logic          wr_en;

  logic [AW+6:0] idx_wide;
  logic [AW+6:0] addr_wide;

  assign idx_wide  = {{(AW+1){1'b0}}, in_slot_index};
  assign addr_wide = {7'd0, addr_r};

  assign sts.in_idx_ok = idx_wide < (AW+7)'(MAX_SLOTS);
  assign sts.match     = rd_used_r && (rd_owner_r == who_r);
  assign sts.cnt_last  = (cnt_r == LAST_SLOT);
  assign sts.head_ok   = (head_r < NULL_SLOT);
  assign sts.det_ok    = rd_used_r && (rd_owner_r == who_r) && (rd_attach_r != 16'd0)
                         && (rd_gen_r == gen_r);
  assign sts.used      = rd_used_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.latch) begin
      if (cmd.load_idx && sts.in_idx_ok) cnt_nxt = idx_wide[CW-1:0];
      else cnt_nxt = '0;
    end else if (cmd.clr_wr || cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      who_r <= in_owner_id;
      gen_r <= in_generation;
      now_r <= in_now_time;
    end
  end

  // read port: slot counter or free head
  assign rd_addr = cmd.rd_head ? head_r[AW-1:0] : cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_cnt || cmd.rd_head) begin
      addr_r       <= rd_addr;
      rd_used_r    <= mem_used[rd_addr];
      rd_owner_r   <= mem_owner[rd_addr];
      rd_attach_r  <= mem_attach[rd_addr];
      rd_gen_r     <= mem_gen[rd_addr];
      rd_created_r <= mem_created[rd_addr];
      rd_next_r    <= mem_next[rd_addr];
    end
  end

  always_comb begin
    nw_used    = rd_used_r;
    nw_owner   = rd_owner_r;
    nw_attach  = rd_attach_r;
    nw_gen     = rd_gen_r;
    nw_created = rd_created_r;
    nw_next    = rd_next_r;
    head_nxt   = head_r;
    case (cmd.wr_op)
      WR_ATTACH_INC: begin
        if (rd_attach_r != ATTACH_MAX) nw_attach = rd_attach_r + 16'd1;
      end
      WR_FREE: begin
        nw_used   = 1'b0;
        nw_attach = 16'd0;
        nw_next   = head_r;
        head_nxt  = {1'b0, addr_r};
      end
      WR_TAKE: begin
        nw_used    = 1'b1;
        nw_owner   = who_r;
        nw_attach  = {15'd0, cmd.take_one};
        nw_gen     = rd_gen_r + 32'd1;
        nw_created = now_r;
        nw_next    = NULL_SLOT;
        head_nxt   = rd_next_r;
      end
      WR_DETACH: begin
        nw_attach = rd_attach_r - 16'd1;
        if (rd_attach_r == 16'd1) begin
          nw_used  = 1'b0;
          nw_next  = head_r;
          head_nxt = {1'b0, addr_r};
        end
      end
      default: ;
    endcase
  end

  assign wr_en   = cmd.clr_wr || (cmd.wr_op != WR_NONE);
  assign wr_addr = cmd.clr_wr ? cnt_r[AW-1:0] : addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (cmd.clr_wr) begin
        mem_used[wr_addr]    <= 1'b0;
        mem_attach[wr_addr]  <= 16'd0;
        mem_gen[wr_addr]     <= 32'd0;
        mem_created[wr_addr] <= 63'd0;
        mem_next[wr_addr]    <= cnt_r + CW'(1);
      end else begin
        mem_used[wr_addr]    <= nw_used;
        mem_attach[wr_addr]  <= nw_attach;
        mem_gen[wr_addr]     <= nw_gen;
        mem_created[wr_addr] <= nw_created;
        mem_next[wr_addr]    <= nw_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op == WR_TAKE) mem_owner[addr_r] <= who_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      if (cmd.status == STS_OK) begin
        out_slot_out       <= addr_wide[5:0];
        out_generation_out <= nw_gen;
        out_attach_out     <= nw_attach;
        out_owner_out      <= nw_owner;
        out_created_out    <= nw_created;
      end else begin
        out_slot_out       <= 6'd0;
        out_generation_out <= 32'd0;
        out_attach_out     <= 16'd0;
        out_owner_out      <= 31'd0;
        out_created_out    <= 63'd0;
      end
    end
  end

endmodule

@@ rtl/process_slot_table_top.sv @@
// Owner slot table with a linked free list. Issue a request by raising start
// while busy is low; the result appears for exactly one cycle with out_strobe
// high, and the receiver cannot stall it, so capture it on that cycle. After
// reset the block sweeps the whole table (busy high) to load reset values and
// the free chain. Table entries are read one at a time through the single
// registered read port: alloc, attach and free search from slot 0, scan from
// slot_index, detach reads only the indexed slot, and unknown kinds read none.
module process_slot_table_top import pst_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [30:0] in_owner_id,
  input  logic [5:0]  in_slot_index,
  input  logic [31:0] in_generation,
  input  logic [62:0] in_now_time,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [31:0] out_generation_out,
  output logic [15:0] out_attach_out,
  output logic [30:0] out_owner_out,
  output logic [62:0] out_created_out
);

  cmd_t cmd;
  sts_t sts;

  // sequence the search, read and write-back steps
  pst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // hold the table, free head and result registers
  pst_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_owner_id        (in_owner_id),
    .in_slot_index      (in_slot_index),
    .in_generation      (in_generation),
    .in_now_time        (in_now_time),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_generation_out (out_generation_out),
    .out_attach_out     (out_attach_out),
    .out_owner_out      (out_owner_out),
    .out_created_out    (out_created_out)
  );

endmodule
